// File: rtl/core/segment_rectangle_hit_test_assert.svh
// Assertion macros for the segment/rectangle hit test pipeline.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef SEGMENT_RECTANGLE_HIT_TEST_ASSERT_SVH
`define SEGMENT_RECTANGLE_HIT_TEST_ASSERT_SVH

// A stage that holds an item and sees no ready keeps the item unchanged.
`define SRHT_HOLD_ON_STALL(label, vld, rdy, dat) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(dat))) \
    else $error("pipeline stage dropped or changed a stalled item");

// In the cycle after the antecedent the consequent holds.
`define SRHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/srht_pkg.sv
// Shared widths and stage payload types for the segment/rectangle hit test.
// No dependencies; every other file of the block but the assertion header refers to it by scope.
`default_nettype none

package srht_pkg;

  // Coordinate width; sizes, extents and products follow from it
  localparam int COORD_WIDTH = 16;
  localparam int NUM_EDGES   = 4;

  localparam int SIZE_W  = COORD_WIDTH - 1;  // box width / height
  localparam int FAR_W   = COORD_WIDTH + 1;  // far corner, never wraps
  localparam int AB_W    = COORD_WIDTH + 1;  // segment direction
  localparam int CD_W    = COORD_WIDTH;      // edge direction, +/- size
  localparam int AC_W    = COORD_WIDTH + 2;  // corner minus segment start
  localparam int PROD_W  = AC_W + AB_W;      // widest single product
  localparam int CROSS_W = PROD_W + 1;       // difference of two products

  // Geometry of one edge relative to the segment start
  typedef struct packed {
    logic signed [AC_W-1:0] acx;
    logic signed [AC_W-1:0] acy;
    logic signed [CD_W-1:0] cdx;
    logic signed [CD_W-1:0] cdy;
  } edge_geo_t;

  typedef struct packed {
    logic signed [AB_W-1:0]           abx;
    logic signed [AB_W-1:0]           aby;
    edge_geo_t [NUM_EDGES-1:0]        edges;
  } geo_t;

  // Six products per edge, paired for the three cross products
  typedef struct packed {
    logic signed [PROD_W-1:0] den_a;
    logic signed [PROD_W-1:0] den_b;
    logic signed [PROD_W-1:0] tn_a;
    logic signed [PROD_W-1:0] tn_b;
    logic signed [PROD_W-1:0] un_a;
    logic signed [PROD_W-1:0] un_b;
  } edge_prod_t;

  typedef edge_prod_t [NUM_EDGES-1:0] prod_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] den;
    logic signed [CROSS_W-1:0] tn;
    logic signed [CROSS_W-1:0] un;
  } edge_cross_t;

  typedef edge_cross_t [NUM_EDGES-1:0] cross_t;

endpackage

`default_nettype wire

// File: rtl/core/srht_if.sv
// Valid/ready channel interfaces for the hit test input and result items.
// Widths come from srht_pkg.
`default_nettype none

interface srht_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [srht_pkg::COORD_WIDTH-1:0] seg_start_x;
  logic signed [srht_pkg::COORD_WIDTH-1:0] seg_start_y;
  logic signed [srht_pkg::COORD_WIDTH-1:0] seg_end_x;
  logic signed [srht_pkg::COORD_WIDTH-1:0] seg_end_y;
  logic signed [srht_pkg::COORD_WIDTH-1:0] box_x;
  logic signed [srht_pkg::COORD_WIDTH-1:0] box_y;
  logic        [srht_pkg::SIZE_W-1:0]      box_w;
  logic        [srht_pkg::SIZE_W-1:0]      box_h;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           box_x, box_y, box_w, box_h,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           box_x, box_y, box_w, box_h,
    output ready
  );
endinterface

interface srht_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

// File: rtl/core/srht_geom.sv
// Stage 1: far corners, segment direction and per-edge differences.
// Uses srht_pkg types and the srht_in_if channel.
`default_nettype none

module srht_geom (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  srht_in_if.sink             in_i,
  input  wire logic           ready_i,
  output logic                valid_o,
  output srht_pkg::geo_t      data_o
);

  localparam int CW   = srht_pkg::COORD_WIDTH;
  localparam int FW   = srht_pkg::FAR_W;
  localparam int CDW  = srht_pkg::CD_W;
  localparam int NE   = srht_pkg::NUM_EDGES;

  logic                 valid_q;
  srht_pkg::geo_t       data_q, data_d;

  logic signed [FW-1:0] x0, y0, x1, y1;
  logic signed [FW-1:0] cx [NE];
  logic signed [FW-1:0] cy [NE];
  logic signed [CDW-1:0] w_pos, h_pos;

  // Extend corners one bit so the far corner never wraps
  assign x0    = signed'({in_i.box_x[CW-1], in_i.box_x});
  assign y0    = signed'({in_i.box_y[CW-1], in_i.box_y});
  assign x1    = x0 + signed'({2'b00, in_i.box_w});
  assign y1    = y0 + signed'({2'b00, in_i.box_h});
  assign w_pos = signed'({1'b0, in_i.box_w});
  assign h_pos = signed'({1'b0, in_i.box_h});

  // Corners in edge order: min corner, then counter-clockwise
  assign cx[0] = x0;
  assign cy[0] = y0;
  assign cx[1] = x1;
  assign cy[1] = y0;
  assign cx[2] = x1;
  assign cy[2] = y1;
  assign cx[3] = x0;
  assign cy[3] = y1;

  // Form the differences for every edge
  always_comb begin
    data_d.abx = signed'({in_i.seg_end_x[CW-1], in_i.seg_end_x})
               - signed'({in_i.seg_start_x[CW-1], in_i.seg_start_x});
    data_d.aby = signed'({in_i.seg_end_y[CW-1], in_i.seg_end_y})
               - signed'({in_i.seg_start_y[CW-1], in_i.seg_start_y});
    for (int k = 0; k < NE; k++) begin
      data_d.edges[k].acx = signed'({cx[k][FW-1], cx[k]})
        - signed'({{2{in_i.seg_start_x[CW-1]}}, in_i.seg_start_x});
      data_d.edges[k].acy = signed'({cy[k][FW-1], cy[k]})
        - signed'({{2{in_i.seg_start_y[CW-1]}}, in_i.seg_start_y});
    end
    // Edge directions: bottom +w, right +h, top -w, left -h
    data_d.edges[0].cdx = w_pos;
    data_d.edges[0].cdy = '0;
    data_d.edges[1].cdx = '0;
    data_d.edges[1].cdy = h_pos;
    data_d.edges[2].cdx = -w_pos;
    data_d.edges[2].cdy = '0;
    data_d.edges[3].cdx = '0;
    data_d.edges[3].cdy = -h_pos;
  end

  // Advance when this stage is empty or the next one takes its item
  assign in_i.ready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/srht_mul.sv
// Stage 2: the six products of the three cross products of every edge.
// Uses srht_pkg types.
`default_nettype none

module srht_mul (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire srht_pkg::geo_t  data_i,
  output logic                 ready_o,
  input  wire logic            ready_i,
  output logic                 valid_o,
  output srht_pkg::prod_t      data_o
);

  logic            valid_q;
  srht_pkg::prod_t data_q, data_d;

  // Multiply each edge's differences against the segment and edge directions
  always_comb begin
    for (int k = 0; k < srht_pkg::NUM_EDGES; k++) begin
      data_d[k].den_a = signed'(data_i.abx) * signed'(data_i.edges[k].cdy);
      data_d[k].den_b = signed'(data_i.aby) * signed'(data_i.edges[k].cdx);
      data_d[k].tn_a  = signed'(data_i.edges[k].acx) * signed'(data_i.edges[k].cdy);
      data_d[k].tn_b  = signed'(data_i.edges[k].acy) * signed'(data_i.edges[k].cdx);
      data_d[k].un_a  = signed'(data_i.edges[k].acx) * signed'(data_i.aby);
      data_d[k].un_b  = signed'(data_i.edges[k].acy) * signed'(data_i.abx);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/srht_cross.sv
// Stage 3: subtract product pairs into den, tn and un for every edge.
// Uses srht_pkg types.
`default_nettype none

module srht_cross (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire srht_pkg::prod_t data_i,
  output logic                 ready_o,
  input  wire logic            ready_i,
  output logic                 valid_o,
  output srht_pkg::cross_t     data_o
);

  localparam int XW = srht_pkg::CROSS_W;

  logic             valid_q;
  srht_pkg::cross_t data_q, data_d;

  // Form the exact cross products, one bit wider than the products
  always_comb begin
    for (int k = 0; k < srht_pkg::NUM_EDGES; k++) begin
      data_d[k].den = XW'(signed'(data_i[k].den_a)) - XW'(signed'(data_i[k].den_b));
      data_d[k].tn  = XW'(signed'(data_i[k].tn_a))  - XW'(signed'(data_i[k].tn_b));
      data_d[k].un  = XW'(signed'(data_i[k].un_a))  - XW'(signed'(data_i[k].un_b));
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/srht_decide.sv
// Stage 4: range tests of tn and un against den, OR over the edges.
// Uses srht_pkg types and drives the srht_out_if result channel.
`default_nettype none

module srht_decide (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire srht_pkg::cross_t data_i,
  output logic                  ready_o,
  srht_out_if.source            out_o
);

  localparam int XW = srht_pkg::CROSS_W;

  logic                        valid_q;
  logic                        hit_q, hit_d;
  logic [srht_pkg::NUM_EDGES-1:0] edge_hit;

  // Test 0 <= v/den <= 1 without dividing, for the sign of den
  function automatic logic in_span(logic signed [XW-1:0] v, logic signed [XW-1:0] d);
    logic v_nonneg, v_nonpos;
    v_nonneg = !v[XW-1];
    v_nonpos = v[XW-1] || (v == '0);
    if (!d[XW-1]) begin
      in_span = v_nonneg && (v <= d);
    end else begin
      in_span = v_nonpos && (v >= d);
    end
  endfunction

  // Parallel edges (den zero) never hit
  always_comb begin
    for (int k = 0; k < srht_pkg::NUM_EDGES; k++) begin
      edge_hit[k] = (data_i[k].den != '0)
                 && in_span(data_i[k].tn, data_i[k].den)
                 && in_span(data_i[k].un, data_i[k].den);
    end
    hit_d = |edge_hit;
  end

  // Output register: hold the result until the sink takes it
  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hit_q <= hit_d;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.hit   = hit_q;

endmodule

`default_nettype wire

// File: rtl/core/segment_rectangle_hit_test.sv
// Segment versus axis-aligned rectangle hit test. Each input item carries a
// segment A-B and a rectangle (minimum corner, width, height) in signed Q12.4;
// each item gives one result item, hit, set when the segment touches any of
// the rectangle's edges, endpoints included. Edges parallel to the segment, and
// edges of zero length, never count as hit. The block takes one item every
// clock cycle unless a stall on the result channel has filled the pipeline.
// There are four register stages: corner and difference formation, 24
// parallel multipliers, cross product subtraction, and the range compare
// that feeds the output register. Each stage advances on its own
// valid/ready, so a stall on the result channel fills the pipeline before
// input ready drops.
// Depends on srht_pkg, srht_if and the stage modules.
`default_nettype none

`include "segment_rectangle_hit_test_assert.svh"

module segment_rectangle_hit_test (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  srht_in_if.sink      in_i,
  srht_out_if.source   out_o
);

  logic              geo_valid, mul_valid, cross_valid;
  logic              mul_ready, cross_ready, decide_ready;
  srht_pkg::geo_t    geo_data;
  srht_pkg::prod_t   mul_data;
  srht_pkg::cross_t  cross_data;

  srht_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .ready_i (mul_ready),
    .valid_o (geo_valid),
    .data_o  (geo_data)
  );

  srht_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geo_valid),
    .data_i  (geo_data),
    .ready_o (mul_ready),
    .ready_i (cross_ready),
    .valid_o (mul_valid),
    .data_o  (mul_data)
  );

  srht_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .data_i  (mul_data),
    .ready_o (cross_ready),
    .ready_i (decide_ready),
    .valid_o (cross_valid),
    .data_o  (cross_data)
  );

  srht_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cross_valid),
    .data_i  (cross_data),
    .ready_o (decide_ready),
    .out_o   (out_o)
  );

  // Stalled stages keep their items; accepted items land in the first stage
  `SRHT_HOLD_ON_STALL(a_geo_hold, geo_valid, mul_ready, geo_data)
  `SRHT_HOLD_ON_STALL(a_mul_hold, mul_valid, cross_ready, mul_data)
  `SRHT_HOLD_ON_STALL(a_cross_hold, cross_valid, decide_ready, cross_data)
  `SRHT_ASSERT_NEXT(a_in_capture, in_i.valid && in_i.ready, geo_valid, "item not captured")

endmodule

`default_nettype wire
